>>> rtl/session_auth_table_defines.svh
// ----------------------------------------------------------------------------
// Session auth table assertion macros
// Concurrent check helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SESSION_AUTH_TABLE_DEFINES_SVH
`define SESSION_AUTH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// expression must hold at every edge outside reset
`define SAT_ASSERT(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);
// antecedent now implies consequent on the next edge
`define SAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SAT_ASSERT(lbl, clk, rstn, expr, msg)
`define SAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and codes of the session auth table.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 4;
  localparam int REQ_W    = 3;
  localparam int WORD_W   = 32;
  localparam int TMO_W    = 16;
  localparam int UCNT_W   = 7;
  localparam int SEC_W    = 64;

  // request types
  localparam logic [REQ_W-1:0] REQ_LOAD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOGIN   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOGOFF  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CHECK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CONNECT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DISCON  = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_NO_USER     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_IN  = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_KEY     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_IN      = 4'd4;
  localparam logic [STATUS_W-1:0] ST_OTHER_IP    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_SESSION = 4'd6;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_EXPIRED     = 4'd8;

  // config register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_UCOUNT  = 1'b1;

  // per-entry session state, all zero after the clear pass
  typedef struct packed {
    logic              logged_in;
    logic              connected;
    logic [WORD_W-1:0] session;
    logic [WORD_W-1:0] ip;
    logic [WORD_W-1:0] stamp;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic                wr;
    logic [STATUS_W-1:0] status;
    row_t                row;
  } eval_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_FINISH
  } fsm_state_t;

endpackage

>>> rtl/sat_ram.sv
// ----------------------------------------------------------------------------
// sat_ram
// Single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sat_eval.sv
// ----------------------------------------------------------------------------
// sat_eval
// Applies one session operation to a fetched entry row.
// ----------------------------------------------------------------------------
module sat_eval (
  input  logic [sat_pkg::REQ_W-1:0]  op,
  input  sat_pkg::row_t              row_i,
  input  logic                       sec_match,
  input  logic [sat_pkg::WORD_W-1:0] tag,
  input  logic [sat_pkg::WORD_W-1:0] ip,
  input  logic [sat_pkg::WORD_W-1:0] now,
  input  logic [sat_pkg::TMO_W-1:0]  timeout,
  output sat_pkg::eval_res_t         res
);

  logic [sat_pkg::WORD_W-1:0] idle;
  logic                       expired;
  sat_pkg::row_t              off_row;

  // idle time wraps modulo 2^32
  assign idle    = now - row_i.stamp;
  assign expired = idle >= sat_pkg::WORD_W'(timeout);

  always_comb begin
    off_row           = row_i;
    off_row.logged_in = 1'b0;
    off_row.session   = '0;
    off_row.stamp     = now;
  end

  always_comb begin
    res.wr     = 1'b0;
    res.status = sat_pkg::ST_UNCHANGED;
    res.row    = row_i;
    case (op)
      sat_pkg::REQ_LOGIN: begin
        if (row_i.logged_in) begin
          if (!expired) begin
            res.status = sat_pkg::ST_ALREADY_IN;
          end else begin
            res.wr     = 1'b1;
            res.row    = off_row;
            res.status = sat_pkg::ST_EXPIRED;
          end
        end else if (!sec_match) begin
          res.status = sat_pkg::ST_BAD_KEY;
        end else begin
          res.wr                  = 1'b1;
          res.row.logged_in       = 1'b1;
          res.row.session         = tag;
          res.row.ip              = ip;
          res.row.stamp           = now;
          res.status              = sat_pkg::ST_OK;
        end
      end
      sat_pkg::REQ_LOGOFF, sat_pkg::REQ_CHECK: begin
        if (!row_i.logged_in) begin
          res.status = sat_pkg::ST_NOT_IN;
        end else if (expired) begin
          res.wr     = 1'b1;
          res.row    = off_row;
          res.status = sat_pkg::ST_EXPIRED;
        end else if (row_i.ip != ip) begin
          res.status = sat_pkg::ST_OTHER_IP;
        end else if (!sec_match) begin
          res.status = sat_pkg::ST_BAD_KEY;
        end else if (row_i.session != tag) begin
          res.status = sat_pkg::ST_BAD_SESSION;
        end else begin
          res.wr     = 1'b1;
          res.status = sat_pkg::ST_OK;
          if (op == sat_pkg::REQ_LOGOFF) begin
            res.row = off_row;
          end else begin
            res.row.stamp = now;
          end
        end
      end
      sat_pkg::REQ_CONNECT: begin
        if (!row_i.connected) begin
          res.wr            = 1'b1;
          res.row.connected = 1'b1;
          res.status        = sat_pkg::ST_OK;
        end
      end
      sat_pkg::REQ_DISCON: begin
        if (row_i.connected) begin
          res.wr            = 1'b1;
          res.row.connected = 1'b0;
          res.status        = sat_pkg::ST_OK;
        end
      end
      default: begin
        res.wr = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/session_auth_table.sv
// ----------------------------------------------------------------------------
// session_auth_table
// User/session table: credential search, login/logoff/check, connect flags.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | word
//  --------+---------------------+-----------------------------------------
//  in      | in_valid/in_ready   | req_type slot user_key secret tag ip now
//  out     | out_valid/out_ready | status found_slot
//  cfg     | cfg_we (no wait)    | cfg_index cfg_data
//
//  Load and unused request types: accept, then the finish step, plus output wait.
//  Search ops: accept cycle, then the scan of the entries in order (credential RAM
//  read port, one compare per cycle; the hit cycle also issues the state RAM
//  read), then eval/write, then the load of the output register; up to
//  min(user_count,MAX_USERS) entries are scanned per word, plus output wait.
//  After reset the state RAM is cleared, all MAX_USERS entries, in_ready low.
//  A word may be accepted while the previous result waits in the output
//  register; the new result then holds until out_ready frees it.
//
module session_auth_table #(
  parameter int MAX_USERS = 64,
  parameter int KEY_BYTES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // config
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [sat_pkg::TMO_W-1:0]    cfg_data,
  // request
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sat_pkg::REQ_W-1:0]    in_req_type,
  input  logic [sat_pkg::SLOT_W-1:0]   in_slot,
  input  logic [sat_pkg::WORD_W-1:0]   in_user_key,
  input  logic [sat_pkg::SEC_W-1:0]    in_secret,
  input  logic [sat_pkg::WORD_W-1:0]   in_session_tag,
  input  logic [sat_pkg::WORD_W-1:0]   in_client_ip,
  input  logic [sat_pkg::WORD_W-1:0]   in_now_seconds,
  // result
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sat_pkg::STATUS_W-1:0] out_status,
  output logic [sat_pkg::SLOT_W-1:0]   out_found_slot
);

`include "session_auth_table_defines.svh"

  localparam int IW  = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int LW  = (IW + 1 > sat_pkg::UCNT_W) ? IW + 1 : sat_pkg::UCNT_W;
  localparam int KW  = 8 * KEY_BYTES;
  localparam int WW  = sat_pkg::WORD_W;
  localparam int CRW = WW + KW;
  localparam int SW  = sat_pkg::SLOT_W;
  localparam int RW  = sat_pkg::ROW_W;

  // config registers
  logic [sat_pkg::TMO_W-1:0]  timeout_r;
  logic [sat_pkg::UCNT_W-1:0] ucount_r;

  // control
  sat_pkg::fsm_state_t state_r, state_nxt;
  logic [IW-1:0] scan_idx_r, scan_idx_nxt;
  logic [IW-1:0] clr_idx_r, clr_idx_nxt;
  logic          out_valid_r, out_valid_nxt;

  // request / result holding (payload, no reset)
  logic [sat_pkg::REQ_W-1:0]    op_r, op_nxt;
  logic [WW-1:0]                key_r, key_nxt;
  logic [KW-1:0]                sec_r, sec_nxt;
  logic [WW-1:0]                tag_r, tag_nxt;
  logic [WW-1:0]                ip_r, ip_nxt;
  logic [WW-1:0]                now_r, now_nxt;
  logic [IW-1:0]                found_r, found_nxt;
  logic [sat_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [sat_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SW-1:0]                out_slot_r, out_slot_nxt;

  // RAM ports
  logic           cr_we, cr_re;
  logic [IW-1:0]  cr_waddr, cr_raddr;
  logic [CRW-1:0] cr_wdata, cr_rdata;
  logic           st_we, st_re;
  logic [IW-1:0]  st_waddr, st_raddr;
  logic [RW-1:0]  st_wdata, st_rdata;

  // misc
  logic               accept;
  logic               is_search;
  logic               slot_ok;
  logic [LW-1:0]      ucount_ext;
  logic [LW-1:0]      limit_w;
  logic               hit;
  logic               scan_last;
  logic               out_free;
  logic               out_load;
  logic               sec_match;
  sat_pkg::row_t      row_rd;
  sat_pkg::eval_res_t ev;
  logic               st_phase_ok;
  logic               scan_in_range;
  logic               status_legal;

  assign accept    = in_valid && in_ready;
  assign is_search = in_req_type inside {sat_pkg::REQ_LOGIN, sat_pkg::REQ_LOGOFF,
                                         sat_pkg::REQ_CHECK, sat_pkg::REQ_CONNECT,
                                         sat_pkg::REQ_DISCON};
  assign slot_ok   = LW'(in_slot) < LW'(MAX_USERS);

  // entries searched: user_count clipped to the table size
  assign ucount_ext = LW'(ucount_r);
  assign limit_w    = (ucount_ext < LW'(MAX_USERS)) ? ucount_ext : LW'(MAX_USERS);

  // credential row: user id above key bytes
  assign hit       = cr_rdata[KW +: WW] == key_r;
  assign scan_last = (LW'(scan_idx_r) + LW'(1)) == limit_w;
  assign sec_match = cr_rdata[KW-1:0] == sec_r;
  assign row_rd    = sat_pkg::row_t'(st_rdata);

  assign out_free = !out_valid_r || out_ready;

  // credential store: user id and key, written by load only
  sat_ram #(.WIDTH(CRW), .DEPTH(MAX_USERS), .AW(IW)) u_cred_ram (
    .clk   (clk),
    .we    (cr_we),
    .waddr (cr_waddr),
    .wdata (cr_wdata),
    .re    (cr_re),
    .raddr (cr_raddr),
    .rdata (cr_rdata)
  );

  // session store: flags, session, ip, last access; cleared after reset
  sat_ram #(.WIDTH(RW), .DEPTH(MAX_USERS), .AW(IW)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  sat_eval u_eval (
    .op        (op_r),
    .row_i     (row_rd),
    .sec_match (sec_match),
    .tag       (tag_r),
    .ip        (ip_r),
    .now       (now_r),
    .timeout   (timeout_r),
    .res       (ev)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sat_pkg::S_CLEAR: begin
        if (clr_idx_r == IW'(MAX_USERS - 1)) begin
          state_nxt = sat_pkg::S_IDLE;
        end
      end
      sat_pkg::S_IDLE: begin
        if (accept) begin
          if (is_search && (limit_w != '0)) begin
            state_nxt = sat_pkg::S_SCAN;
          end else begin
            state_nxt = sat_pkg::S_FINISH;
          end
        end
      end
      sat_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = sat_pkg::S_EVAL;
        end else if (scan_last) begin
          state_nxt = sat_pkg::S_FINISH;
        end
      end
      sat_pkg::S_EVAL: begin
        state_nxt = sat_pkg::S_FINISH;
      end
      sat_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = sat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sat_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready       = 1'b0;
    out_load       = 1'b0;
    cr_we          = 1'b0;
    cr_waddr       = IW'(in_slot);
    cr_wdata       = {in_user_key, in_secret[KW-1:0]};
    cr_re          = 1'b0;
    cr_raddr       = '0;
    st_we          = 1'b0;
    st_waddr       = found_r;
    st_wdata       = ev.row;
    st_re          = 1'b0;
    st_raddr       = scan_idx_r;
    scan_idx_nxt   = scan_idx_r;
    clr_idx_nxt    = clr_idx_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    sec_nxt        = sec_r;
    tag_nxt        = tag_r;
    ip_nxt         = ip_r;
    now_nxt        = now_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;

    case (state_r)
      sat_pkg::S_CLEAR: begin
        st_we       = 1'b1;
        st_waddr    = clr_idx_r;
        st_wdata    = '0;
        clr_idx_nxt = clr_idx_r + IW'(1);
      end
      sat_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          op_nxt       = in_req_type;
          key_nxt      = in_user_key;
          sec_nxt      = in_secret[KW-1:0];
          tag_nxt      = in_session_tag;
          ip_nxt       = in_client_ip;
          now_nxt      = in_now_seconds;
          found_nxt    = '0;
          scan_idx_nxt = '0;
          if (in_req_type == sat_pkg::REQ_LOAD) begin
            if (slot_ok) begin
              cr_we          = 1'b1;
              found_nxt      = IW'(in_slot);
              res_status_nxt = sat_pkg::ST_OK;
            end else begin
              res_status_nxt = sat_pkg::ST_NO_USER;
            end
          end else if (!is_search) begin
            res_status_nxt = sat_pkg::ST_UNCHANGED;
          end else if (limit_w == '0) begin
            res_status_nxt = sat_pkg::ST_NO_USER;
          end else begin
            // first credential read goes out with the accept
            cr_re = 1'b1;
          end
        end
      end
      sat_pkg::S_SCAN: begin
        if (hit) begin
          // credential data stays put: no further read until next word
          found_nxt = scan_idx_r;
          st_re     = 1'b1;
        end else if (scan_last) begin
          found_nxt      = '0;
          res_status_nxt = sat_pkg::ST_NO_USER;
        end else begin
          cr_re        = 1'b1;
          cr_raddr     = scan_idx_r + IW'(1);
          scan_idx_nxt = scan_idx_r + IW'(1);
        end
      end
      sat_pkg::S_EVAL: begin
        st_we          = ev.wr;
        res_status_nxt = ev.status;
      end
      sat_pkg::S_FINISH: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = SW'(found_r);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sat_pkg::S_CLEAR;
      scan_idx_r  <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      timeout_r   <= sat_pkg::TMO_W'(300);
      ucount_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == sat_pkg::CFG_TIMEOUT) begin
          timeout_r <= cfg_data;
        end else begin
          ucount_r <= cfg_data[sat_pkg::UCNT_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    sec_r        <= sec_nxt;
    tag_r        <= tag_nxt;
    ip_r         <= ip_nxt;
    now_r        <= now_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_slot = out_slot_r;

  // check terms
  assign st_phase_ok   = (state_r == sat_pkg::S_CLEAR) || (state_r == sat_pkg::S_EVAL);
  assign scan_in_range = (state_r != sat_pkg::S_SCAN) || (LW'(scan_idx_r) < limit_w);
  assign status_legal  = out_status_r <= sat_pkg::ST_EXPIRED;

  // in the cycle after an accept the block is busy
  `SAT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_ready, "ready after accept")
  // state RAM is only written by the clear pass or the eval step
  `SAT_ASSERT(a_st_we_phase, clk, rst_n, !st_we || st_phase_ok, "state write out of phase")
  // the scan never runs past the searched range
  `SAT_ASSERT(a_scan_range, clk, rst_n, scan_in_range, "scan index past limit")
  // a pending result is never overwritten
  `SAT_ASSERT(a_no_overwrite, clk, rst_n, !out_load || out_free, "result overwritten")
  // status codes stay within the defined set
  `SAT_ASSERT(a_status_range, clk, rst_n, !out_valid_r || status_legal, "bad status code")

endmodule

>>> verif/tb_session_auth_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_session_auth_table
// Self-checking bench for the session auth table. A queue of requests feeds a
// valid/ready driver; a clocked monitor mirrors every accepted word into a
// table model of its own and checks each result word in order. Directed
// login/check/logoff/connect cases run first, then randomized traffic over
// several timeout and user-count settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_session_auth_table;
  import sat_pkg::*;

  // request codes the block treats as no-ops
  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  localparam int ENTRIES  = 64;
  localparam int ID_POOL  = 40;
  localparam int HOLD_LEN = 400;  // long receiver hold-off, in cycles

  typedef struct packed {
    logic [REQ_W-1:0]    kind;
    logic [SLOT_W-1:0]   slot;
    logic [WORD_W-1:0]   user_key;
    logic [SEC_W-1:0]    secret;
    logic [WORD_W-1:0]   tag;
    logic [WORD_W-1:0]   ip;
    logic [WORD_W-1:0]   now;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   found;
  } outcome_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [TMO_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0] out_found_slot;
  request_t offered = '0;  // word currently presented on the in channel

  session_auth_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (offered.kind),
    .in_slot        (offered.slot),
    .in_user_key    (offered.user_key),
    .in_secret      (offered.secret),
    .in_session_tag (offered.tag),
    .in_client_ip   (offered.ip),
    .in_now_seconds (offered.now),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found_slot (out_found_slot)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  request_t pend_q[$];     // requests waiting for the driver
  outcome_t expect_q[$];   // predicted result words, oldest first
  outcome_t head;
  logic     in_took = 1'b0;  // word accepted at the last rising edge
  logic     no_idle = 1'b0;  // both sides run flat out
  logic     hold_req = 1'b0; // ask the receiver for its long hold-off
  logic     hold_done = 1'b0;
  int       hold_left = 0;
  int       err_cnt = 0;
  int       n_taken = 0;
  int       n_results = 0;
  int       n_writes = 0;
  logic [15:0] status_seen = '0;

  // register copies used by the table model and the generator
  logic [TMO_W-1:0]  tmo_reg = 16'd300;
  logic [UCNT_W-1:0] ucnt_reg = '0;

  // table model
  logic [WORD_W-1:0] tbl_user [ENTRIES];
  logic [SEC_W-1:0]  tbl_secret [ENTRIES];
  logic              tbl_in [ENTRIES];
  logic              tbl_conn [ENTRIES];
  logic [WORD_W-1:0] tbl_sess [ENTRIES];
  logic [WORD_W-1:0] tbl_ip [ENTRIES];
  logic [WORD_W-1:0] tbl_last [ENTRIES];

  // generator's view: what was loaded where, and the last login offered
  logic [WORD_W-1:0] gen_id [ENTRIES];
  logic [SEC_W-1:0]  gen_key [ENTRIES];
  logic [WORD_W-1:0] gen_tag [ENTRIES];
  logic [WORD_W-1:0] gen_ip [ENTRIES];
  logic [WORD_W-1:0] gen_now = '0;
  logic [WORD_W-1:0] id_pool [ID_POOL];

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_in[i] = 1'b0;
      tbl_conn[i] = 1'b0;
      tbl_sess[i] = '0;
      tbl_ip[i] = '0;
      tbl_last[i] = '0;
      tbl_user[i] = '0;
      tbl_secret[i] = '0;
      gen_tag[i] = '0;
      gen_ip[i] = '0;
      gen_id[i] = '0;
      gen_key[i] = '0;
    end
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    err_cnt++;
    if (err_cnt <= 100)
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------
  // idle time is modulo 2^32; a zero timeout expires everything
  function automatic logic session_stale(int e, logic [WORD_W-1:0] now);
    logic [WORD_W-1:0] idle;
    idle = now - tbl_last[e];
    return idle >= {16'h0, tmo_reg};
  endfunction

  function automatic void close_session(int e, logic [WORD_W-1:0] now);
    tbl_last[e] = now;
    tbl_in[e] = 1'b0;
    tbl_sess[e] = '0;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int lim;
    int hit;
    int e;
    o.status = ST_OK;
    o.found = '0;
    hit = -1;
    if (r.kind == REQ_LOAD) begin
      tbl_user[r.slot] = r.user_key;
      tbl_secret[r.slot] = r.secret;
      o.found = r.slot;
      return o;
    end
    if (r.kind inside {REQ_RSVD6, REQ_RSVD7}) begin
      o.status = ST_UNCHANGED;
      return o;
    end
    // count above table size searches the whole table; first match wins
    lim = (int'(ucnt_reg) > ENTRIES) ? ENTRIES : int'(ucnt_reg);
    for (int i = 0; i < lim; i++)
      if (hit < 0 && tbl_user[i] == r.user_key) hit = i;
    if (hit < 0) begin
      o.status = ST_NO_USER;
      return o;
    end
    e = hit;
    o.found = e[SLOT_W-1:0];
    case (r.kind)
      REQ_LOGIN: begin
        if (tbl_in[e]) begin
          if (!session_stale(e, r.now)) begin
            o.status = ST_ALREADY_IN;
          end else begin
            close_session(e, r.now);
            o.status = ST_EXPIRED;
          end
        end else if (tbl_secret[e] != r.secret) begin
          o.status = ST_BAD_KEY;
        end else begin
          tbl_last[e] = r.now;
          tbl_in[e] = 1'b1;
          tbl_sess[e] = r.tag;
          tbl_ip[e] = r.ip;
        end
      end
      REQ_LOGOFF, REQ_CHECK: begin
        // order matters: login, expiry, ip, key, session
        if (!tbl_in[e]) begin
          o.status = ST_NOT_IN;
        end else if (session_stale(e, r.now)) begin
          close_session(e, r.now);
          o.status = ST_EXPIRED;
        end else if (tbl_ip[e] != r.ip) begin
          o.status = ST_OTHER_IP;
        end else if (tbl_secret[e] != r.secret) begin
          o.status = ST_BAD_KEY;
        end else if (tbl_sess[e] != r.tag) begin
          o.status = ST_BAD_SESSION;
        end else if (r.kind == REQ_LOGOFF) begin
          close_session(e, r.now);
        end else begin
          tbl_last[e] = r.now;
        end
      end
      REQ_CONNECT: begin
        if (tbl_conn[e]) o.status = ST_UNCHANGED;
        else tbl_conn[e] = 1'b1;
      end
      default: begin
        if (!tbl_conn[e]) o.status = ST_UNCHANGED;
        else tbl_conn[e] = 1'b0;
      end
    endcase
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request generation
  // --------------------------------------------------------------------------
  function automatic request_t mk(logic [REQ_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                  logic [WORD_W-1:0] id, logic [SEC_W-1:0] key,
                                  logic [WORD_W-1:0] tag, logic [WORD_W-1:0] ip,
                                  logic [WORD_W-1:0] now);
    request_t r;
    r.kind = kind;
    r.slot = slot;
    r.user_key = id;
    r.secret = key;
    r.tag = tag;
    r.ip = ip;
    r.now = now;
    return r;
  endfunction

  task automatic enqueue(request_t r);
    if (r.kind == REQ_LOAD) begin
      gen_id[r.slot] = r.user_key;
      gen_key[r.slot] = r.secret;
    end
    pend_q.push_back(r);
  endtask

  function automatic logic [REQ_W-1:0] pick_op();
    int p;
    p = $urandom_range(99);
    if (p < 30) return REQ_LOGIN;
    if (p < 60) return REQ_CHECK;
    if (p < 72) return REQ_LOGOFF;
    if (p < 86) return REQ_CONNECT;
    return REQ_DISCON;
  endfunction

  // Mostly well-formed traffic against loaded ids, with a little noise:
  // bad keys/ips/tags, unknown ids, reserved codes and reloads.
  function automatic request_t make_request();
    request_t r;
    int p;
    int lim;
    int s;
    r = mk(REQ_CHECK, SLOT_W'($urandom), $urandom, {$urandom, $urandom}, $urandom,
           $urandom, '0);
    p = $urandom_range(99);
    if (p < 70) gen_now += $urandom_range(0, tmo_reg / 8 + 1);
    else if (p < 95) gen_now += $urandom_range(0, 2 * tmo_reg + 2);
    else gen_now = $urandom;
    r.now = gen_now;
    p = $urandom_range(99);
    if (p < 8) begin
      r.kind = REQ_LOAD;
      if ($urandom_range(19) != 0) r.user_key = id_pool[$urandom_range(ID_POOL - 1)];
    end else if (p < 10) begin
      r.kind = $urandom_range(1) ? REQ_RSVD6 : REQ_RSVD7;
    end else if (p < 15) begin
      r.kind = pick_op();
    end else begin
      lim = (int'(ucnt_reg) > ENTRIES) ? ENTRIES : int'(ucnt_reg);
      s = (lim == 0) ? $urandom_range(ENTRIES - 1) : $urandom_range(lim - 1);
      r.user_key = gen_id[s];
      r.kind = pick_op();
      if (r.kind == REQ_LOGIN) begin
        if ($urandom_range(99) < 85) r.secret = gen_key[s];
        gen_tag[s] = r.tag;
        gen_ip[s] = r.ip;
      end else if (r.kind inside {REQ_CHECK, REQ_LOGOFF}) begin
        if ($urandom_range(99) < 85) r.ip = gen_ip[s];
        if ($urandom_range(99) < 90) r.secret = gen_key[s];
        if ($urandom_range(99) < 88) r.tag = gen_tag[s];
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: new word at the falling edge once the last one was taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pend_q.size() != 0 && (no_idle || $urandom_range(99) >= 19)) begin
        offered <= pend_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 19);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results first, then predict the word accepted this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        n_results++;
        status_seen[out_status] = 1'b1;
        if (expect_q.size() == 0) begin
          report_mismatch("result word with nothing pending", 64'(out_status), 0);
        end else begin
          head = expect_q.pop_front();
          if (out_status !== head.status)
            report_mismatch("status", 64'(out_status), 64'(head.status));
          if (out_found_slot !== head.found)
            report_mismatch("found_slot", 64'(out_found_slot), 64'(head.found));
        end
      end
      if (in_valid && in_ready) begin
        n_taken++;
        expect_q.push_back(apply_request(offered));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  // sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drain();
    do @(negedge clk); while (pend_q.size() != 0 || in_valid || expect_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [TMO_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT) tmo_reg = val;
    else ucnt_reg = val[UCNT_W-1:0];
    n_writes++;
  endtask

  task automatic run_phase(logic [TMO_W-1:0] tmo, logic [UCNT_W-1:0] ucnt, int n);
    wait_drain();
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_UCOUNT, {{(TMO_W - UCNT_W){1'b0}}, ucnt});
    for (int i = 0; i < n; i++) enqueue(make_request());
  endtask

  localparam logic [WORD_W-1:0] ID_A  = 32'h1234_5678;
  localparam logic [SEC_W-1:0]  KEY_A = 64'h0123_4567_89AB_CDEF;
  localparam logic [WORD_W-1:0] TAG_A = 32'hCAFE_0001;
  localparam logic [WORD_W-1:0] IP_A  = 32'h0A00_0001;
  localparam logic [WORD_W-1:0] ONES  = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] ID_HI = 32'h8000_0001;

  initial begin
    for (int i = 0; i < ID_POOL; i++) id_pool[i] = $urandom;

    // synchronous reset, then wait out the state clear pass
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (!in_ready);

    // reset settings: nothing searched yet, reserved codes are no-ops
    enqueue(mk(REQ_CHECK, 0, ID_A, KEY_A, TAG_A, IP_A, 0));
    enqueue(mk(REQ_RSVD6, 6'h2A, ONES, '1, ONES, ONES, ONES));
    enqueue(mk(REQ_RSVD7, 6'h15, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_LOAD, 0, 0, 64'h0, 0, 0, 0));
    enqueue(mk(REQ_LOAD, 1, ID_A, KEY_A, 0, 0, 0));
    enqueue(mk(REQ_LOAD, 2, ID_A, ~KEY_A, 0, 0, 0));   // duplicate id, loses
    enqueue(mk(REQ_LOAD, 3, ONES, '1, 0, 0, 0));
    enqueue(mk(REQ_LOAD, 63, ID_HI, 64'h8000_0000_0000_0001, 0, 0, 0));

    wait_drain();
    write_reg(CFG_TIMEOUT, 16'd100);
    write_reg(CFG_UCOUNT, 16'd4);
    // login/check/logoff walk through every rejection in order
    enqueue(mk(REQ_LOGIN, 0, ID_A, ~KEY_A, TAG_A, IP_A, 32'd990));
    enqueue(mk(REQ_LOGIN, 0, ID_A, KEY_A, TAG_A, IP_A, 32'd1000));
    enqueue(mk(REQ_LOGIN, 0, ID_A, KEY_A, TAG_A, IP_A, 32'd1001));
    enqueue(mk(REQ_CHECK, 0, ID_A, KEY_A, TAG_A, IP_A + 1, 32'd1010));
    enqueue(mk(REQ_CHECK, 0, ID_A, KEY_A ^ 64'd1, TAG_A, IP_A, 32'd1020));
    enqueue(mk(REQ_CHECK, 0, ID_A, KEY_A, TAG_A + 1, IP_A, 32'd1030));
    enqueue(mk(REQ_CHECK, 0, ID_A, KEY_A, TAG_A, IP_A, 32'd1050));
    enqueue(mk(REQ_LOGOFF, 0, ID_A, KEY_A, TAG_A, IP_A, 32'd1150));  // idle == timeout
    enqueue(mk(REQ_LOGOFF, 0, ID_A, KEY_A, TAG_A, IP_A, 32'd1151));
    // all-ones entry, session straddling the 32-bit time wrap
    enqueue(mk(REQ_LOGIN, 0, ONES, '1, ONES, ONES, 32'hFFFF_FFF0));
    enqueue(mk(REQ_CHECK, 0, ONES, '1, ONES, ONES, 32'h0000_0050));
    enqueue(mk(REQ_LOGOFF, 0, ONES, '1, ONES, ONES, 32'h0000_0051));
    enqueue(mk(REQ_CONNECT, 0, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_CONNECT, 0, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_DISCON, 0, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_DISCON, 0, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_LOGIN, 0, 0, 0, 0, 0, 0));
    enqueue(mk(REQ_CHECK, 0, ID_HI, 0, 0, 0, 5));  // loaded but past the count

    // fill the rest of the table so any count searches only loaded entries
    gen_now = 32'd2000;
    for (int s = 4; s < ENTRIES - 1; s++)
      enqueue(mk(REQ_LOAD, SLOT_W'(s), id_pool[$urandom_range(ID_POOL - 1)],
                 {$urandom, $urandom}, 0, 0, 0));

    // zero timeout, oversized count; long receiver hold-off fills the block
    hold_req = 1'b1;
    run_phase(16'd0, 7'd127, 200);
    // flat out, longest timeout, clock close to the wrap
    run_phase(16'hFFFF, 7'd64, 220);
    wait_drain();
    no_idle = 1'b1;
    gen_now = ONES - $urandom_range(0, 200000);
    run_phase(16'hFFFF, 7'd64, 220);
    wait_drain();
    no_idle = 1'b0;
    run_phase(16'd1, 7'd1, 200);
    run_phase(TMO_W'($urandom_range(20, 600)), UCNT_W'($urandom_range(1, 64)), 220);
    run_phase(16'd300, 7'd0, 60);
    run_phase(TMO_W'($urandom_range(1, 65535)), 7'd16, 200);
    run_phase(TMO_W'($urandom_range(2, 200)), UCNT_W'($urandom_range(1, 64)), 295);

    // done: drain, let the pipe settle, then tally
    wait_drain();
    repeat (200) @(posedge clk);
    if (expect_q.size() != 0)
      report_mismatch("results never delivered", 64'(expect_q.size()), 0);
    $display("Run covered %0d requests and %0d results over %0d register writes",
             n_taken, n_results, n_writes);
    $display("Status codes returned (one bit per code): %b", status_seen);
    if (err_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
